// ===== rtl/fdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdf_pkg
// Shared types, codes and constants of the fall detector core.
// ----------------------------------------------------------------------------
package fdf_pkg;

  // defaults of the top level parameters
  localparam int ONE_G_UNITS = 256;
  localparam int AXIS_BITS   = 16;

  // field widths
  localparam int AXIS_W   = 16;
  localparam int NOW_W    = 32;
  localparam int MAG_W    = 16;
  localparam int PHASE_W  = 2;
  localparam int CFG_W    = 16;
  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W   = 5;
  localparam int APB_W    = 32;

  // stream packing
  localparam int IN_X_LSB   = 0;
  localparam int IN_Y_LSB   = 16;
  localparam int IN_Z_LSB   = 32;
  localparam int IN_NOW_LSB = 48;
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int USER_VALID = 0;
  localparam int USER_CLEAR = 1;
  localparam int OUT_DATA_W = 24;

  // fall phases
  localparam logic [PHASE_W-1:0] PH_MON    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_LOW_G  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_IMPACT = 2'd2;
  localparam logic [PHASE_W-1:0] PH_ALERT  = 2'd3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_LOW_G_LEVEL    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMPACT_LEVEL   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STILL_BAND     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STILL_DELTA    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOW_G_HOLD     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FALL_WINDOW    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_STILL_HOLD     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_IMPACT_TIMEOUT = 3'd7;

  // register reset values
  localparam logic [CFG_W-1:0] RST_LOW_G_LEVEL    = 16'd115;
  localparam logic [CFG_W-1:0] RST_IMPACT_LEVEL   = 16'd640;
  localparam logic [CFG_W-1:0] RST_STILL_BAND     = 16'd90;
  localparam logic [CFG_W-1:0] RST_STILL_DELTA    = 16'd26;
  localparam logic [CFG_W-1:0] RST_LOW_G_HOLD     = 16'd120;
  localparam logic [CFG_W-1:0] RST_FALL_WINDOW    = 16'd1500;
  localparam logic [CFG_W-1:0] RST_STILL_HOLD     = 16'd2500;
  localparam logic [CFG_W-1:0] RST_IMPACT_TIMEOUT = 16'd8000;

  // axis select for the shared squarer
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] low_g_level;
    logic [CFG_W-1:0] impact_level;
    logic [CFG_W-1:0] still_band;
    logic [CFG_W-1:0] still_delta;
    logic [CFG_W-1:0] low_g_hold_ms;
    logic [CFG_W-1:0] fall_window_ms;
    logic [CFG_W-1:0] still_hold_ms;
    logic [CFG_W-1:0] impact_timeout_ms;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       time_en;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_en;
    logic       root_step;
    logic       update;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/fdf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdf_ctrl
// Sequencer: load, three squaring steps, one root bit per cycle, update.
// ----------------------------------------------------------------------------
module fdf_ctrl #(
  parameter int AXIS_BITS = fdf_pkg::AXIS_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  fdf_pkg::stat_t stat,
  output logic           in_ready,
  output fdf_pkg::cmd_t  cmd
);

  localparam int CNT_W = $clog2(AXIS_BITS);
  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(AXIS_BITS - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SQUARE = 2'd1;
  localparam logic [1:0] ST_ROOT   = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mul_sel   = fdf_pkg::SEL_X;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQUARE;
          cnt_nxt   = '0;
        end
      end
      ST_SQUARE: begin
        cmd.time_en = (cnt_r == '0);
        cmd.mul_en  = (cnt_r != SQ_LAST);
        cmd.acc_en  = (cnt_r != '0);
        case (cnt_r[1:0])
          2'd0:    cmd.mul_sel = fdf_pkg::SEL_X;
          2'd1:    cmd.mul_sel = fdf_pkg::SEL_Y;
          2'd2:    cmd.mul_sel = fdf_pkg::SEL_Z;
          default: cmd.mul_sel = fdf_pkg::SEL_X;
        endcase
        if (cnt_r == SQ_LAST) begin
          state_nxt = ST_ROOT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_r == ROOT_LAST) begin
          state_nxt = ST_UPDATE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_UPDATE: begin
        if (stat.out_free) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/fdf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdf_dp
// Datapath: squarer, accumulator, bit-serial square root, phase logic and
// the result register.
// ----------------------------------------------------------------------------
module fdf_dp #(
  parameter int ONE_G_UNITS = fdf_pkg::ONE_G_UNITS,
  parameter int AXIS_BITS   = fdf_pkg::AXIS_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fdf_pkg::cmd_t                     cmd,
  input  fdf_pkg::cfg_t                     cfg,
  input  logic [fdf_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [fdf_pkg::IN_USER_W-1:0]     in_tuser,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [fdf_pkg::OUT_DATA_W-1:0]    out_tdata,
  output fdf_pkg::stat_t                    stat
);

  localparam int A      = AXIS_BITS;
  localparam int SUM_W  = 2 * A;
  localparam int REM_W  = A + 1;
  localparam int TRY_W  = A + 4;
  localparam int MAG_W  = fdf_pkg::MAG_W;
  localparam int NOW_W  = fdf_pkg::NOW_W;
  localparam logic [MAG_W:0] ONE_G = (MAG_W + 1)'(ONE_G_UNITS);

  // sample registers
  logic signed [A-1:0] ax_r, ay_r, az_r;
  logic [NOW_W-1:0]    now_r;
  logic                valid_r, clear_r;

  // arithmetic registers
  logic [SUM_W-1:0] prod_r;
  logic [SUM_W-1:0] acc_r;
  logic [REM_W-1:0] rem_r;
  logic [A-1:0]     root_r;

  // elapsed time flags
  logic lg_hold_ok_r, fw_exp_r, still_ok_r, imp_exp_r;

  // detector state
  logic [fdf_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [NOW_W-1:0]            low_g_since_r, low_g_since_nxt;
  logic                        low_g_timing_r, low_g_timing_nxt;
  logic [NOW_W-1:0]            phase_since_r, phase_since_nxt;
  logic [NOW_W-1:0]            still_since_r, still_since_nxt;
  logic                        still_timing_r, still_timing_nxt;
  logic [MAG_W-1:0]            last_mag_r, last_mag_nxt;

  // result register
  logic                                out_valid_r;
  logic [fdf_pkg::OUT_DATA_W-1:0]      out_data_r, out_data_nxt;

  logic signed [A-1:0]   mul_op;
  logic signed [SUM_W-1:0] square;
  logic [TRY_W-1:0]      rem_sh, trial;
  logic [NOW_W-1:0]      el_low, el_phase, el_still;
  logic [MAG_W-1:0]      mag;
  logic [MAG_W:0]        dist_one_g, dist_last;
  logic                  still, alert_start;

  // squarer operand select
  always_comb begin
    case (cmd.mul_sel)
      fdf_pkg::SEL_X: mul_op = ax_r;
      fdf_pkg::SEL_Y: mul_op = ay_r;
      fdf_pkg::SEL_Z: mul_op = az_r;
      default:        mul_op = ax_r;
    endcase
    square = mul_op * mul_op;
  end

  // one root bit per step
  assign rem_sh = {1'b0, rem_r, acc_r[SUM_W-1 -: 2]};
  assign trial  = rem_sh - {2'b00, root_r, 2'b01};

  // elapsed times, modulo 2^32
  assign el_low   = now_r - low_g_since_r;
  assign el_phase = now_r - phase_since_r;
  assign el_still = now_r - still_since_r;

  // magnitude compares
  assign mag        = valid_r ? MAG_W'(root_r) : '0;
  assign dist_one_g = ({1'b0, mag} >= ONE_G) ? ({1'b0, mag} - ONE_G) : (ONE_G - {1'b0, mag});
  assign dist_last  = (mag >= last_mag_r) ? ({1'b0, mag} - {1'b0, last_mag_r})
                                          : ({1'b0, last_mag_r} - {1'b0, mag});
  assign still      = (dist_one_g < {1'b0, cfg.still_band}) &&
                      (dist_last < {1'b0, cfg.still_delta});

  // phase machine of the detector
  always_comb begin
    phase_nxt        = phase_r;
    low_g_since_nxt  = low_g_since_r;
    low_g_timing_nxt = low_g_timing_r;
    phase_since_nxt  = phase_since_r;
    still_since_nxt  = still_since_r;
    still_timing_nxt = still_timing_r;
    last_mag_nxt     = last_mag_r;
    alert_start      = 1'b0;

    // acknowledge acts before the sample
    if (phase_r == fdf_pkg::PH_ALERT && clear_r) begin
      phase_nxt        = fdf_pkg::PH_MON;
      low_g_timing_nxt = 1'b0;
      still_timing_nxt = 1'b0;
    end

    if (valid_r) begin
      case (phase_nxt)
        fdf_pkg::PH_MON: begin
          if (mag < cfg.low_g_level) begin
            if (!low_g_timing_nxt) begin
              low_g_since_nxt  = now_r;
              low_g_timing_nxt = 1'b1;
            end else if (lg_hold_ok_r) begin
              phase_nxt       = fdf_pkg::PH_LOW_G;
              phase_since_nxt = now_r;
            end
          end else begin
            low_g_timing_nxt = 1'b0;
          end
        end
        fdf_pkg::PH_LOW_G: begin
          if (mag > cfg.impact_level) begin
            phase_nxt        = fdf_pkg::PH_IMPACT;
            phase_since_nxt  = now_r;
            still_timing_nxt = 1'b0;
          end else if (fw_exp_r) begin
            phase_nxt        = fdf_pkg::PH_MON;
            low_g_timing_nxt = 1'b0;
          end
        end
        fdf_pkg::PH_IMPACT: begin
          if (still) begin
            if (!still_timing_nxt) begin
              still_since_nxt  = now_r;
              still_timing_nxt = 1'b1;
            end else if (still_ok_r) begin
              phase_nxt   = fdf_pkg::PH_ALERT;
              alert_start = 1'b1;
            end
          end else begin
            still_timing_nxt = 1'b0;
          end
          if (!alert_start && imp_exp_r) begin
            phase_nxt        = fdf_pkg::PH_MON;
            low_g_timing_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
      last_mag_nxt = mag;
    end

    out_data_nxt = {4'b0000, mag, alert_start, (phase_nxt != phase_r), phase_nxt};
  end

  // sample capture and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r    <= in_tdata[fdf_pkg::IN_X_LSB +: A];
      ay_r    <= in_tdata[fdf_pkg::IN_Y_LSB +: A];
      az_r    <= in_tdata[fdf_pkg::IN_Z_LSB +: A];
      now_r   <= in_tdata[fdf_pkg::IN_NOW_LSB +: NOW_W];
      valid_r <= in_tuser[fdf_pkg::USER_VALID];
      clear_r <= in_tuser[fdf_pkg::USER_CLEAR];
      acc_r   <= '0;
      rem_r   <= '0;
      root_r  <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + prod_r;
    end else if (cmd.root_step) begin
      acc_r <= {acc_r[SUM_W-3:0], 2'b00};
      if (!trial[TRY_W-1]) begin
        rem_r  <= trial[REM_W-1:0];
        root_r <= {root_r[A-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[REM_W-1:0];
        root_r <= {root_r[A-2:0], 1'b0};
      end
    end
    if (cmd.mul_en) begin
      prod_r <= $unsigned(square);
    end
    if (cmd.time_en) begin
      lg_hold_ok_r <= el_low >= NOW_W'(cfg.low_g_hold_ms);
      fw_exp_r     <= el_phase > NOW_W'(cfg.fall_window_ms);
      imp_exp_r    <= el_phase > NOW_W'(cfg.impact_timeout_ms);
      still_ok_r   <= el_still >= NOW_W'(cfg.still_hold_ms);
    end
    if (cmd.update) begin
      out_data_r <= out_data_nxt;
    end
  end

  // detector state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= fdf_pkg::PH_MON;
      low_g_since_r  <= '0;
      low_g_timing_r <= 1'b0;
      phase_since_r  <= '0;
      still_since_r  <= '0;
      still_timing_r <= 1'b0;
      last_mag_r     <= MAG_W'(ONE_G_UNITS);
      out_valid_r    <= 1'b0;
    end else begin
      if (cmd.update) begin
        phase_r        <= phase_nxt;
        low_g_since_r  <= low_g_since_nxt;
        low_g_timing_r <= low_g_timing_nxt;
        phase_since_r  <= phase_since_nxt;
        still_since_r  <= still_since_nxt;
        still_timing_r <= still_timing_nxt;
        last_mag_r     <= last_mag_nxt;
      end
      if (cmd.update) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign stat.out_free = !out_valid_r || out_tready;

endmodule

// ===== rtl/fall_detector_fsm_core.sv =====
`timescale 1ns / 1ps
// Sequence: each item passes through the input transfer, the squarer steps, one square
//   root bit per cycle and the result update, which waits while the previous result
//   is held in the output register; a new input is taken only once the update is done.
// Reset: synchronous active-low rst_n returns the detector to monitoring, the
//   registers to their defaults and the last magnitude to one g.
// ----------------------------------------------------------------------------
// fall_detector_fsm_core
// Accelerometer fall detector: magnitude, free fall, impact and stillness.
// ----------------------------------------------------------------------------
module fall_detector_fsm_core #(
  parameter int ONE_G_UNITS = fdf_pkg::ONE_G_UNITS,
  parameter int AXIS_BITS   = fdf_pkg::AXIS_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], now_ms[79:48]
  input  logic [fdf_pkg::IN_DATA_W-1:0]     in_tdata,
  // sample_valid[0], clear_alert[1]
  input  logic [fdf_pkg::IN_USER_W-1:0]     in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // phase[1:0], phase_changed[2], alert_start[3], magnitude[19:4], zero[23:20]
  output logic [fdf_pkg::OUT_DATA_W-1:0]    out_tdata,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fdf_pkg::ADDR_W-1:0]        paddr,
  input  logic [fdf_pkg::APB_W-1:0]         pwdata,
  output logic [fdf_pkg::APB_W-1:0]         prdata,
  output logic                              pready
);

  logic [fdf_pkg::CFG_W-1:0]     regs_r [fdf_pkg::NUM_REGS];
  logic [fdf_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          reg_wr;
  fdf_pkg::cfg_t                 cfg;
  fdf_pkg::cmd_t                 cmd;
  fdf_pkg::stat_t                stat;
  logic                          in_fire;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[fdf_pkg::ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;
  assign prdata  = {{(fdf_pkg::APB_W - fdf_pkg::CFG_W){1'b0}}, regs_r[reg_idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[fdf_pkg::REG_LOW_G_LEVEL]    <= fdf_pkg::RST_LOW_G_LEVEL;
      regs_r[fdf_pkg::REG_IMPACT_LEVEL]   <= fdf_pkg::RST_IMPACT_LEVEL;
      regs_r[fdf_pkg::REG_STILL_BAND]     <= fdf_pkg::RST_STILL_BAND;
      regs_r[fdf_pkg::REG_STILL_DELTA]    <= fdf_pkg::RST_STILL_DELTA;
      regs_r[fdf_pkg::REG_LOW_G_HOLD]     <= fdf_pkg::RST_LOW_G_HOLD;
      regs_r[fdf_pkg::REG_FALL_WINDOW]    <= fdf_pkg::RST_FALL_WINDOW;
      regs_r[fdf_pkg::REG_STILL_HOLD]     <= fdf_pkg::RST_STILL_HOLD;
      regs_r[fdf_pkg::REG_IMPACT_TIMEOUT] <= fdf_pkg::RST_IMPACT_TIMEOUT;
    end else if (reg_wr) begin
      regs_r[reg_idx] <= pwdata[fdf_pkg::CFG_W-1:0];
    end
  end

  assign cfg.low_g_level       = regs_r[fdf_pkg::REG_LOW_G_LEVEL];
  assign cfg.impact_level      = regs_r[fdf_pkg::REG_IMPACT_LEVEL];
  assign cfg.still_band        = regs_r[fdf_pkg::REG_STILL_BAND];
  assign cfg.still_delta       = regs_r[fdf_pkg::REG_STILL_DELTA];
  assign cfg.low_g_hold_ms     = regs_r[fdf_pkg::REG_LOW_G_HOLD];
  assign cfg.fall_window_ms    = regs_r[fdf_pkg::REG_FALL_WINDOW];
  assign cfg.still_hold_ms     = regs_r[fdf_pkg::REG_STILL_HOLD];
  assign cfg.impact_timeout_ms = regs_r[fdf_pkg::REG_IMPACT_TIMEOUT];

  // input transfer
  assign in_fire = in_tvalid && in_tready;

  // sequencer
  fdf_ctrl #(
    .AXIS_BITS (AXIS_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .stat     (stat),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  // datapath
  fdf_dp #(
    .ONE_G_UNITS (ONE_G_UNITS),
    .AXIS_BITS   (AXIS_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .stat       (stat)
  );

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // a new result only comes from an item in work
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without an item in work");

  // alert entry is a phase change into alert
  a_alert_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |->
      out_tdata[1:0] == fdf_pkg::PH_ALERT && out_tdata[2])
    else $error("alert start outside alert entry");

endmodule
